FILE: rtl/core/tpsd_pkg.sv
// tpsd_pkg: types and constants for the TCP payload signature detector.
// No dependencies; the top level, parser and checker use it by scoped names.

package tpsd_pkg;

  // Default sizes handed to the top-level parameters
  localparam int MAX_FRAME_BYTES_DEF = 65536;
  localparam int HEAD_BYTES_DEF      = 8;
  localparam int HEAD_BITS           = 64;

  // Header field positions and sizes in bytes (TCP_OFFSET_POS counts from the TCP header)
  localparam int ETHERTYPE_HI_POS = 12;
  localparam int ETHERTYPE_LO_POS = 13;
  localparam int ETH_HDR_BYTES    = 14;
  localparam int IP_VER_IHL_POS   = 14;
  localparam int IP_PROTO_POS     = 23;
  localparam int SRC_ADDR_POS     = 26;
  localparam int DST_ADDR_POS     = 30;
  localparam int ADDR_BYTES       = 4;
  localparam int TCP_PORT_BYTES   = 4;
  localparam int TCP_OFFSET_POS   = 12;

  // Header values
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [3:0]  IPV4_VERSION   = 4'd4;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [5:0]  MIN_HDR_BYTES  = 6'd20;

  // Payload signatures
  localparam logic [7:0]  SIG_ABRIDGED     = 8'hEF;
  localparam logic [31:0] SIG_INTERMEDIATE = 32'hEEEEEEEE;
  localparam logic [31:0] SIG_PADDED       = 32'hDDDDDDDD;
  localparam logic [3:0]  SIG_WORD_BYTES   = 4'd4;

  typedef enum logic [1:0] {
    KIND_NONE         = 2'd0,
    KIND_ABRIDGED     = 2'd1,
    KIND_INTERMEDIATE = 2'd2,
    KIND_PADDED       = 2'd3
  } sig_kind_t;

  // Verdict of the frame in progress, as seen after the current byte
  typedef struct packed {
    sig_kind_t              kind;
    logic [31:0]            src_addr;
    logic [31:0]            dst_addr;
    logic [15:0]            sport;
    logic [15:0]            dport;
    logic [HEAD_BITS-1:0]   head;
    logic [3:0]             head_count;
  } frame_verdict_t;

endpackage

FILE: rtl/core/tpsd_in_if.sv
// tpsd_in_if: byte channel into the detector (valid/ready handshake).
// Depends on nothing.

interface tpsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_last;

  modport source (output valid, output data_byte, output frame_last, input ready);
  modport sink (input valid, input data_byte, input frame_last, output ready);
endinterface

FILE: rtl/core/tpsd_out_if.sv
// tpsd_out_if: verdict channel out of the detector (valid/ready handshake).
// Depends on nothing.

interface tpsd_out_if;
  logic        valid;
  logic        ready;
  logic        detected;
  logic [1:0]  signature_kind;
  logic [31:0] source_address;
  logic [31:0] destination_address;
  logic [15:0] source_port;
  logic [15:0] destination_port;
  logic [63:0] payload_head;
  logic [3:0]  head_count;
  logic [31:0] frames_seen;
  logic [31:0] frames_detected;

  modport source (
    output valid, output detected, output signature_kind, output source_address,
    output destination_address, output source_port, output destination_port,
    output payload_head, output head_count, output frames_seen, output frames_detected,
    input ready
  );
  modport sink (
    input valid, input detected, input signature_kind, input source_address,
    input destination_address, input source_port, input destination_port,
    input payload_head, input head_count, input frames_seen, input frames_detected,
    output ready
  );
endinterface

FILE: rtl/core/tcp_payload_signature_detector.sv
// Top level of the TCP payload signature detector: input register, parser,
// saturating frame counters and the verdict output register.
// A verdict enters the output register when its last byte leaves the input register.
// Throughput: 1 byte per cycle; input stalls only when a last byte meets an
// untaken verdict in the output register.
// Reset (rst, synchronous): clears frame state, counters and both valids.

module tcp_payload_signature_detector #(
  parameter int MAX_FRAME_BYTES = tpsd_pkg::MAX_FRAME_BYTES_DEF,
  parameter int HEAD_BYTES      = tpsd_pkg::HEAD_BYTES_DEF
) (
  input logic        clk,
  input logic        rst,
  tpsd_in_if.sink    octets,
  tpsd_out_if.source verdicts
);

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       step;

  // Counters
  logic [31:0] total_frames, total_frames_next;
  logic [31:0] matched_frames, matched_frames_next;

  tpsd_pkg::frame_verdict_t verdict;
  logic hit;

  // A registered byte moves on unless it ends a frame while a verdict waits
  assign step         = in_valid && (!in_last || !verdicts.valid || verdicts.ready);
  assign octets.ready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (octets.ready) begin
      in_valid <= octets.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (octets.valid && octets.ready) begin
      in_byte <= octets.data_byte;
      in_last <= octets.frame_last;
    end
  end

  tpsd_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .HEAD_BYTES      (HEAD_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .data_byte  (in_byte),
    .frame_last (in_last),
    .verdict    (verdict)
  );

  // Saturating counters
  always_comb begin
    hit                 = (verdict.kind != tpsd_pkg::KIND_NONE);
    total_frames_next   = (total_frames == '1) ? total_frames : 32'(total_frames + 1'b1);
    matched_frames_next = (hit && (matched_frames != '1)) ?
                          32'(matched_frames + 1'b1) : matched_frames;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_frames   <= '0;
      matched_frames <= '0;
    end else if (step && in_last) begin
      total_frames   <= total_frames_next;
      matched_frames <= matched_frames_next;
    end
  end

  // Verdict output register
  always_ff @(posedge clk) begin
    if (rst) begin
      verdicts.valid <= 1'b0;
    end else if (step && in_last) begin
      verdicts.valid <= 1'b1;
    end else if (verdicts.ready) begin
      verdicts.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last) begin
      verdicts.detected            <= hit;
      verdicts.signature_kind      <= verdict.kind;
      verdicts.source_address      <= verdict.src_addr;
      verdicts.destination_address <= verdict.dst_addr;
      verdicts.source_port         <= verdict.sport;
      verdicts.destination_port    <= verdict.dport;
      verdicts.payload_head        <= verdict.head;
      verdicts.head_count          <= verdict.head_count;
      verdicts.frames_seen         <= total_frames_next;
      verdicts.frames_detected     <= matched_frames_next;
    end
  end

endmodule

FILE: rtl/core/tpsd_parser.sv
// tpsd_parser: per-frame header parse state and payload capture.
// Depends on tpsd_pkg. Gives the verdict as it stands after the stepped byte.

module tpsd_parser #(
  parameter int MAX_FRAME_BYTES = tpsd_pkg::MAX_FRAME_BYTES_DEF,
  parameter int HEAD_BYTES      = tpsd_pkg::HEAD_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic [7:0]               data_byte,
  input  logic                     frame_last,
  output tpsd_pkg::frame_verdict_t verdict
);

  localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CW = (PW > 8) ? PW : 8;
  localparam int IW = (HEAD_BYTES > 1) ? $clog2(HEAD_BYTES) : 1;

  // Frame state
  logic [PW-1:0] pos, pos_next;
  logic [15:0]   eth_word, eth_word_next;
  logic [5:0]    ip_hdr, ip_hdr_next;
  logic [5:0]    tcp_hdr, tcp_hdr_next;
  logic          rejected, rejected_next;
  logic [31:0]   src_addr, src_addr_next;
  logic [31:0]   dst_addr, dst_addr_next;
  logic [31:0]   ports, ports_next;
  logic [7:0]    head [HEAD_BYTES];
  logic [7:0]    head_next [HEAD_BYTES];
  logic [3:0]    head_count, head_count_next;

  logic [CW-1:0] p;
  logic [CW-1:0] tcp_start;
  logic [15:0]   eth_shift;
  logic [tpsd_pkg::HEAD_BITS-1:0] head_word;
  logic          frame_ok;
  tpsd_pkg::sig_kind_t kind;

  // Next-state parse of one byte
  always_comb begin
    pos_next        = pos;
    eth_word_next   = eth_word;
    ip_hdr_next     = ip_hdr;
    tcp_hdr_next    = tcp_hdr;
    rejected_next   = rejected;
    src_addr_next   = src_addr;
    dst_addr_next   = dst_addr;
    ports_next      = ports;
    head_next       = head;
    head_count_next = head_count;
    p               = CW'(pos);
    tcp_start       = CW'(tpsd_pkg::ETH_HDR_BYTES) + CW'(ip_hdr);
    eth_shift       = {eth_word[7:0], data_byte};

    // bytes past the size limit are not parsed
    if (step && (pos < PW'(MAX_FRAME_BYTES))) begin
      pos_next = PW'(pos + 1'b1);
      if (!rejected) begin
        if ((p == CW'(tpsd_pkg::ETHERTYPE_HI_POS)) || (p == CW'(tpsd_pkg::ETHERTYPE_LO_POS))) begin
          eth_word_next = eth_shift;
          if ((p == CW'(tpsd_pkg::ETHERTYPE_LO_POS)) && (eth_shift != tpsd_pkg::ETHERTYPE_IPV4)) begin
            rejected_next = 1'b1;
          end
        end else if (p < CW'(tpsd_pkg::ETH_HDR_BYTES)) begin
          // MAC addresses: nothing kept
        end else if (p == CW'(tpsd_pkg::IP_VER_IHL_POS)) begin
          ip_hdr_next = {data_byte[3:0], 2'b00};
          if ((data_byte[7:4] != tpsd_pkg::IPV4_VERSION) ||
              ({data_byte[3:0], 2'b00} < tpsd_pkg::MIN_HDR_BYTES)) begin
            rejected_next = 1'b1;
          end
        end else if (p == CW'(tpsd_pkg::IP_PROTO_POS)) begin
          if (data_byte != tpsd_pkg::PROTO_TCP) begin
            rejected_next = 1'b1;
          end
        end else begin
          // IP addresses
          if ((p >= CW'(tpsd_pkg::SRC_ADDR_POS)) &&
              (p < CW'(tpsd_pkg::SRC_ADDR_POS + tpsd_pkg::ADDR_BYTES))) begin
            src_addr_next = {src_addr[23:0], data_byte};
          end else if ((p >= CW'(tpsd_pkg::DST_ADDR_POS)) &&
                       (p < CW'(tpsd_pkg::DST_ADDR_POS + tpsd_pkg::ADDR_BYTES))) begin
            dst_addr_next = {dst_addr[23:0], data_byte};
          end
          // TCP header and payload
          if (p >= tcp_start) begin
            if (p < CW'(tcp_start + CW'(tpsd_pkg::TCP_PORT_BYTES))) begin
              ports_next = {ports[23:0], data_byte};
            end else if (p == CW'(tcp_start + CW'(tpsd_pkg::TCP_OFFSET_POS))) begin
              tcp_hdr_next = {data_byte[7:4], 2'b00};
              if ({data_byte[7:4], 2'b00} < tpsd_pkg::MIN_HDR_BYTES) begin
                rejected_next = 1'b1;
              end
            end else if ((tcp_hdr != 6'd0) && (p >= CW'(tcp_start + CW'(tcp_hdr))) &&
                         (head_count < 4'(HEAD_BYTES))) begin
              head_next[head_count[IW-1:0]] = data_byte;
              head_count_next = 4'(head_count + 1'b1);
            end
          end
        end
      end
    end
  end

  // Payload head packed first byte on top, zero filled
  always_comb begin
    head_word = '0;
    for (int i = 0; i < HEAD_BYTES; i++) begin
      head_word[tpsd_pkg::HEAD_BITS-1-8*i -: 8] = head_next[i];
    end
  end

  // Signature match on the updated state
  always_comb begin
    frame_ok = !rejected_next && (tcp_hdr_next != 6'd0) && (head_count_next != 4'd0);
    kind     = tpsd_pkg::KIND_NONE;
    if (frame_ok) begin
      if (head_word[63:56] == tpsd_pkg::SIG_ABRIDGED) begin
        kind = tpsd_pkg::KIND_ABRIDGED;
      end else if ((head_count_next >= tpsd_pkg::SIG_WORD_BYTES) &&
                   (head_word[63:32] == tpsd_pkg::SIG_INTERMEDIATE)) begin
        kind = tpsd_pkg::KIND_INTERMEDIATE;
      end else if ((head_count_next >= tpsd_pkg::SIG_WORD_BYTES) &&
                   (head_word[63:32] == tpsd_pkg::SIG_PADDED)) begin
        kind = tpsd_pkg::KIND_PADDED;
      end
    end

    verdict = '0;
    verdict.kind = kind;
    if (kind != tpsd_pkg::KIND_NONE) begin
      verdict.src_addr   = src_addr_next;
      verdict.dst_addr   = dst_addr_next;
      verdict.sport      = ports_next[31:16];
      verdict.dport      = ports_next[15:0];
      verdict.head       = head_word;
      verdict.head_count = head_count_next;
    end
  end

  // State registers: cleared on reset and after each last byte
  always_ff @(posedge clk) begin
    if (rst || (step && frame_last)) begin
      pos        <= '0;
      eth_word   <= '0;
      ip_hdr     <= '0;
      tcp_hdr    <= '0;
      rejected   <= 1'b0;
      src_addr   <= '0;
      dst_addr   <= '0;
      ports      <= '0;
      head_count <= '0;
      for (int i = 0; i < HEAD_BYTES; i++) begin
        head[i] <= '0;
      end
    end else if (step) begin
      pos        <= pos_next;
      eth_word   <= eth_word_next;
      ip_hdr     <= ip_hdr_next;
      tcp_hdr    <= tcp_hdr_next;
      rejected   <= rejected_next;
      src_addr   <= src_addr_next;
      dst_addr   <= dst_addr_next;
      ports      <= ports_next;
      head_count <= head_count_next;
      head       <= head_next;
    end
  end

endmodule

FILE: rtl/core/tpsd_checker.sv
// tpsd_checker: port-level assertions for the detector, bound to its top.
// Depends on tpsd_pkg, tpsd_in_if and tpsd_out_if.

module tpsd_checker (
  input logic        clk,
  input logic        rst,
  tpsd_in_if.sink    octets,
  tpsd_out_if.source verdicts
);

  // A stalled verdict stays offered
  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    verdicts.valid && !verdicts.ready |=> verdicts.valid)
    else $error("verdict dropped while stalled");

  // A stalled verdict keeps its counters
  a_counts_hold: assert property (@(posedge clk) disable iff (rst)
    verdicts.valid && !verdicts.ready |=>
      $stable(verdicts.frames_seen) && $stable(verdicts.frames_detected))
    else $error("verdict changed while stalled");

  // Detection flag, kind and counters agree
  a_detect_kind: assert property (@(posedge clk) disable iff (rst)
    verdicts.valid |->
      (verdicts.detected == (verdicts.signature_kind != tpsd_pkg::KIND_NONE)) &&
      (verdicts.frames_detected <= verdicts.frames_seen) &&
      (verdicts.frames_seen != 32'd0))
    else $error("inconsistent verdict");

  // A miss carries no frame details
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    verdicts.valid && !verdicts.detected |->
      (verdicts.payload_head == 64'd0) && (verdicts.head_count == 4'd0) &&
      (verdicts.source_address == 32'd0) && (verdicts.source_port == 16'd0))
    else $error("miss verdict carries data");

  // Four-byte signatures need four payload bytes
  a_word_sig_len: assert property (@(posedge clk) disable iff (rst)
    verdicts.valid && ((verdicts.signature_kind == tpsd_pkg::KIND_INTERMEDIATE) ||
                       (verdicts.signature_kind == tpsd_pkg::KIND_PADDED)) |->
      (verdicts.head_count >= 4'd4))
    else $error("word signature on short payload");

endmodule

bind tcp_payload_signature_detector tpsd_checker u_tpsd_checker (
  .clk      (clk),
  .rst      (rst),
  .octets   (octets),
  .verdicts (verdicts)
);
